// ----- design/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// shared constants for the rotation matrix to euler angles core
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int GUARD_SHIFT = 12;
  localparam int GUARD_BITS  = 16;

  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INNER_AXIS     = 3'd0,
    REG_ODD_PARITY     = 3'd1,
    REG_AXIS_REPEATS   = 3'd2,
    REG_ROTATING_FRAME = 3'd3,
    REG_NEAR_ZERO_THR  = 3'd4
  } cfg_reg_t;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam axis_t NEXT_AXIS [4] = '{AXIS_Y, AXIS_Z, AXIS_X, AXIS_Y};

  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ----- design/rme_cordic.sv -----
// ----------------------------------------------------------------------------
// rme_cordic
// pipelined cordic vectoring: quadrant fold stage then one stage per step
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int W = 32,
  parameter int N = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic signed [W-1:0] x_out,
  output logic        [31:0]  z_out
);
  import rme_pkg::*;

  logic signed [W-1:0] x_r    [N+1];
  logic signed [W-1:0] y_r    [N+1];
  logic        [31:0]  z_r    [N+1];
  logic                zero_r [N+1];

  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      x_r[0] <= -x_in;
      y_r[0] <= -y_in;
      z_r[0] <= HALF_TURN;
    end else begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      z_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    always_ff @(posedge clk) begin
      zero_r[s+1] <= zero_r[s];
      if (y_r[s] >= 0) begin
        x_r[s+1] <= x_r[s] + (y_r[s] >>> s);
        y_r[s+1] <= y_r[s] - (x_r[s] >>> s);
        z_r[s+1] <= z_r[s] + ATAN_TURN32[s];
      end else begin
        x_r[s+1] <= x_r[s] - (y_r[s] >>> s);
        y_r[s+1] <= y_r[s] + (x_r[s] >>> s);
        z_r[s+1] <= z_r[s] - ATAN_TURN32[s];
      end
    end
  end

  assign x_out = x_r[N];
  assign z_out = zero_r[N] ? 32'd0 : z_r[N];

endmodule

// ----- design/rotation_matrix_to_euler_angles_core.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core
// the result path is set by two cordic runs
// in series: magnitude run, then the second-angle run fed by that magnitude
// throughput one item per cycle, busy never rises, results cannot be stalled
// synchronous active-low reset clears config registers and valid pipeline
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_core #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r0c0,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r0c1,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r0c2,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r1c0,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r1c1,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r1c2,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r2c0,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r2c1,
  input  logic signed [ELEMENT_WIDTH-1:0]    in_r2c2,
  input  logic                               cfg_we,
  input  logic [rme_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rme_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  output logic signed [ANGLE_WIDTH-1:0]      out_angle_first,
  output logic signed [ANGLE_WIDTH-1:0]      out_angle_second,
  output logic signed [ANGLE_WIDTH-1:0]      out_angle_third,
  output logic                               out_gimbal_lock
);
  import rme_pkg::*;

  localparam int EW  = ELEMENT_WIDTH;
  localparam int W   = ELEMENT_WIDTH + GUARD_BITS;
  localparam int LC  = CORDIC_STAGES + 1;
  localparam int LAT = 2 * LC + 5;

  // config registers
  axis_t       cfg_inner_r;
  logic        cfg_parity_r;
  logic        cfg_repeats_r;
  logic        cfg_frame_r;
  logic [14:0] cfg_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_inner_r   <= AXIS_X;
      cfg_parity_r  <= 1'b0;
      cfg_repeats_r <= 1'b0;
      cfg_frame_r   <= 1'b0;
      cfg_thr_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INNER_AXIS:     cfg_inner_r   <= cfg_wdata[1:0];
        REG_ODD_PARITY:     cfg_parity_r  <= cfg_wdata[0];
        REG_AXIS_REPEATS:   cfg_repeats_r <= cfg_wdata[0];
        REG_ROTATING_FRAME: cfg_frame_r   <= cfg_wdata[0];
        REG_NEAR_ZERO_THR:  cfg_thr_r     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // valid pipeline
  logic accept;
  logic [LAT-1:0] v_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], accept};
    end
  end

  // input register
  logic signed [EW-1:0] m_r [3][3];

  always_ff @(posedge clk) begin
    m_r[0][0] <= in_r0c0;
    m_r[0][1] <= in_r0c1;
    m_r[0][2] <= in_r0c2;
    m_r[1][0] <= in_r1c0;
    m_r[1][1] <= in_r1c1;
    m_r[1][2] <= in_r1c2;
    m_r[2][0] <= in_r2c0;
    m_r[2][1] <= in_r2c1;
    m_r[2][2] <= in_r2c2;
  end

  // axis selection and operand setup
  function automatic logic signed [W-1:0] ext(input logic signed [EW-1:0] e);
    ext = {{(W-EW-GUARD_SHIFT){e[EW-1]}}, e, {GUARD_SHIFT{1'b0}}};
  endfunction

  axis_t ax_i, ax_j, ax_k;
  logic signed [W-1:0] e_ii, e_ij, e_ik, e_ji, e_jj, e_jk, e_ki, e_kj, e_kk;

  always_comb begin
    ax_i = (cfg_inner_r > AXIS_Z) ? AXIS_X : cfg_inner_r;
    ax_j = NEXT_AXIS[2'(ax_i + axis_t'(cfg_parity_r))];
    ax_k = NEXT_AXIS[2'(ax_i + 2'd1 - axis_t'(cfg_parity_r))];
    e_ii = ext(m_r[ax_i][ax_i]);
    e_ij = ext(m_r[ax_i][ax_j]);
    e_ik = ext(m_r[ax_i][ax_k]);
    e_ji = ext(m_r[ax_j][ax_i]);
    e_jj = ext(m_r[ax_j][ax_j]);
    e_jk = ext(m_r[ax_j][ax_k]);
    e_ki = ext(m_r[ax_k][ax_i]);
    e_kj = ext(m_r[ax_k][ax_j]);
    e_kk = ext(m_r[ax_k][ax_k]);
  end

  logic signed [W-1:0] ax_r, ay_r, rx_r, ry_r, sx_r, sy_r, bop_r;

  always_ff @(posedge clk) begin
    sx_r <= e_jj;
    sy_r <= -e_jk;
    if (cfg_repeats_r) begin
      ax_r  <= e_ik;
      ay_r  <= e_ij;
      rx_r  <= -e_ki;
      ry_r  <= e_ji;
      bop_r <= e_ii;
    end else begin
      ax_r  <= e_ii;
      ay_r  <= e_ji;
      rx_r  <= e_kk;
      ry_r  <= e_kj;
      bop_r <= -e_ki;
    end
  end

  // first cordic runs
  logic signed [W-1:0] a_x;
  logic [31:0] a_z, r_z, s_z;
  logic signed [W-1:0] r_xu, s_xu;

  rme_cordic #(.W(W), .N(CORDIC_STAGES)) u_cordic_a (
    .clk(clk), .x_in(ax_r), .y_in(ay_r), .x_out(a_x), .z_out(a_z)
  );
  rme_cordic #(.W(W), .N(CORDIC_STAGES)) u_cordic_r (
    .clk(clk), .x_in(rx_r), .y_in(ry_r), .x_out(r_xu), .z_out(r_z)
  );
  rme_cordic #(.W(W), .N(CORDIC_STAGES)) u_cordic_s (
    .clk(clk), .x_in(sx_r), .y_in(sy_r), .x_out(s_xu), .z_out(s_z)
  );

  // gain compensation
  logic [63:0] raw64;
  logic [63:0] prod_lo_r, prod_hi_r, mag_sum;
  logic [W-1:0] mag_r;

  assign raw64 = (a_x < 0) ? 64'd0 : 64'(unsigned'(a_x));

  always_ff @(posedge clk) begin
    prod_lo_r <= {32'd0, raw64[31:0]} * {32'd0, INV_GAIN_Q32};
    prod_hi_r <= {32'd0, raw64[63:32]} * {32'd0, INV_GAIN_Q32};
    mag_r     <= mag_sum[W-1:0];
  end

  assign mag_sum = prod_hi_r + {32'd0, prod_lo_r[63:32]};

  // delay lines
  logic signed [W-1:0] bop_dly_r [LC+2];
  logic [31:0] a_dly_r [LC+2];
  logic [31:0] r_dly_r [LC+2];
  logic [31:0] s_dly_r [LC+2];
  logic        sing_dly_r [LC];
  logic        sing_nxt;

  assign sing_nxt = mag_r <= W'({cfg_thr_r, {GUARD_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    bop_dly_r[0]  <= bop_r;
    a_dly_r[0]    <= a_z;
    r_dly_r[0]    <= r_z;
    s_dly_r[0]    <= s_z;
    sing_dly_r[0] <= sing_nxt;
    for (int n = 1; n < LC + 2; n++) begin
      bop_dly_r[n] <= bop_dly_r[n-1];
      a_dly_r[n]   <= a_dly_r[n-1];
      r_dly_r[n]   <= r_dly_r[n-1];
      s_dly_r[n]   <= s_dly_r[n-1];
    end
    for (int n = 1; n < LC; n++) begin
      sing_dly_r[n] <= sing_dly_r[n-1];
    end
  end

  // second angle run
  logic signed [W-1:0] bx, by, b_xu;
  logic [31:0] b_z;

  assign bx = cfg_repeats_r ? bop_dly_r[LC+1] : $signed(mag_r);
  assign by = cfg_repeats_r ? $signed(mag_r) : bop_dly_r[LC+1];

  rme_cordic #(.W(W), .N(CORDIC_STAGES)) u_cordic_b (
    .clk(clk), .x_in(bx), .y_in(by), .x_out(b_xu), .z_out(b_z)
  );

  // branch select, parity, frame swap and rounding
  logic        sing;
  logic [31:0] a1, a2, a3, f1, f3;
  logic [ANGLE_WIDTH-1:0] q1, q2, q3;

  function automatic logic [ANGLE_WIDTH-1:0] to_out(input logic [31:0] z);
    logic [31:0] t;
    if (ANGLE_WIDTH < 32) begin
      t = z + (32'd1 << (31 - ANGLE_WIDTH));
    end else begin
      t = z;
    end
    to_out = t[31 -: ANGLE_WIDTH];
  endfunction

  always_comb begin
    sing = sing_dly_r[LC-1];
    if (sing) begin
      a1 = s_dly_r[LC+1];
      a3 = '0;
    end else if (cfg_repeats_r) begin
      a1 = a_dly_r[LC+1];
      a3 = r_dly_r[LC+1];
    end else begin
      a1 = r_dly_r[LC+1];
      a3 = a_dly_r[LC+1];
    end
    a2 = b_z;
    if (cfg_parity_r) begin
      a1 = 32'd0 - a1;
      a2 = 32'd0 - a2;
      a3 = 32'd0 - a3;
    end
    f1 = cfg_frame_r ? a3 : a1;
    f3 = cfg_frame_r ? a1 : a3;
    q1 = to_out(f1);
    q2 = to_out(a2);
    q3 = to_out(f3);
  end

  logic signed [ANGLE_WIDTH-1:0] out_first_r, out_second_r, out_third_r;
  logic out_lock_r;

  always_ff @(posedge clk) begin
    out_first_r  <= q1;
    out_second_r <= q2;
    out_third_r  <= q3;
    out_lock_r   <= sing;
  end

  assign out_valid        = v_r[LAT-1];
  assign out_angle_first  = out_first_r;
  assign out_angle_second = out_second_r;
  assign out_angle_third  = out_third_r;
  assign out_gimbal_lock  = out_lock_r;

endmodule

// ----- design/rme_checker.sv -----
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks for the rotation matrix to euler angles core
// ----------------------------------------------------------------------------
module rme_checker #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [ANGLE_WIDTH-1:0] out_angle_first,
  input logic signed [ANGLE_WIDTH-1:0] out_angle_third,
  input logic                          out_gimbal_lock
);

  localparam int LAT = 2 * CORDIC_STAGES + 7;

  // every result comes from an item accepted earlier by the core
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching item");

  // singular branch zeroes one of the outer angles
  a_lock_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gimbal_lock) |-> (out_angle_third == '0 || out_angle_first == '0))
    else $error("gimbal lock with no zero outer angle");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind rotation_matrix_to_euler_angles_core rme_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_rme_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_angle_first(out_angle_first),
  .out_angle_third(out_angle_third),
  .out_gimbal_lock(out_gimbal_lock)
);
